FILE: hdl/ldf_pkg.sv
// Shared types, register indexes and defaults for the length-framed byte deframer.
package ldf_pkg;

  localparam int STORE_DEPTH_DEF = 32;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT = 2'd1;

  localparam logic [7:0] FRAME_ID_RST  = 8'd0;
  localparam logic [7:0] GAP_LIMIT_RST = 8'd10;
  localparam logic [7:0] GAP_SAT       = 8'hFF;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [4:0] byte_index;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [1:0] q_level;
    logic       back_busy;
  } front_stat_t;

endpackage

FILE: hdl/ldf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ldf_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [W-1:0]             wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [W-1:0]             rd_data
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/ldf_front.sv
// Front end: config registers, gap counter, frame parser, store writes and dump commands.
module ldf_front
  import ldf_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  in_t                                 in_data,
  input  logic                                cfg_valid,
  input  logic [CFG_IDX_W-1:0]                cfg_index,
  input  logic [7:0]                          cfg_data,
  input  front_stat_t                         stat,
  output logic                                wr_en,
  output logic [$clog2(STORE_DEPTH):0]        wr_addr,
  output logic [7:0]                          wr_data,
  output logic                                push,
  output logic [$clog2(STORE_DEPTH+1):0]      push_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam logic [7:0]    DEPTH_B = 8'(STORE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
  localparam logic [7:0]    MIN_LEN = 8'd3;

  logic [7:0]    frame_id_r, gap_limit_r;
  logic          receiving_r, receiving_nxt;
  logic [CW-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]    frame_length_r, frame_length_nxt;
  logic [7:0]    gap_ticks_r, gap_ticks_nxt;
  logic          bank_r, bank_nxt;

  logic          accept, timeout, recv_eff;
  logic [CW-1:0] cnt_eff, cnt_inc;
  logic [7:0]    need;
  logic [1:0]    outstanding;

  // Two banks of the store; stall while both are owned by pending dumps.
  assign outstanding = stat.q_level + {1'b0, stat.back_busy};
  assign in_ready    = (outstanding < 2'd2);
  assign accept      = in_valid & in_ready;

  assign timeout  = (gap_ticks_r == GAP_SAT) || (gap_ticks_r > gap_limit_r);
  assign recv_eff = receiving_r & ~timeout;
  assign cnt_eff  = timeout ? '0 : byte_count_r;
  assign cnt_inc  = cnt_eff + 1'b1;
  assign need     = (frame_length_r < MIN_LEN) ? MIN_LEN : frame_length_r;

  always_comb begin
    receiving_nxt    = receiving_r;
    byte_count_nxt   = byte_count_r;
    frame_length_nxt = frame_length_r;
    gap_ticks_nxt    = gap_ticks_r;
    bank_nxt         = bank_r;
    wr_en            = 1'b0;
    wr_addr          = {bank_r, AW'(cnt_eff)};
    wr_data          = in_data.rx_byte;
    push             = 1'b0;
    push_data        = {bank_r, cnt_inc};
    if (accept) begin
      if (in_data.opcode == OP_TICK) begin
        if (gap_ticks_r != GAP_SAT) begin
          gap_ticks_nxt = gap_ticks_r + 8'd1;
        end
      end else begin
        gap_ticks_nxt  = 8'd0;
        receiving_nxt  = recv_eff;
        byte_count_nxt = cnt_eff;
        if (!recv_eff) begin
          if (in_data.rx_byte == frame_id_r) begin
            wr_en          = 1'b1;
            byte_count_nxt = cnt_inc;
            receiving_nxt  = 1'b1;
          end
        end else if (cnt_eff == CW'(1)) begin
          frame_length_nxt = in_data.rx_byte;
          if (in_data.rx_byte > DEPTH_B) begin
            receiving_nxt  = 1'b0;
            byte_count_nxt = '0;
          end else begin
            wr_en          = 1'b1;
            byte_count_nxt = cnt_inc;
          end
        end else if (cnt_eff >= DEPTH_C) begin
          receiving_nxt  = 1'b0;
          byte_count_nxt = '0;
        end else begin
          wr_en          = 1'b1;
          byte_count_nxt = cnt_inc;
          if (8'(cnt_inc) >= need) begin
            push           = 1'b1;
            bank_nxt       = ~bank_r;
            receiving_nxt  = 1'b0;
            byte_count_nxt = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_id_r     <= FRAME_ID_RST;
      gap_limit_r    <= GAP_LIMIT_RST;
      receiving_r    <= 1'b0;
      byte_count_r   <= '0;
      frame_length_r <= 8'd0;
      gap_ticks_r    <= 8'd0;
      bank_r         <= 1'b0;
    end else begin
      receiving_r    <= receiving_nxt;
      byte_count_r   <= byte_count_nxt;
      frame_length_r <= frame_length_nxt;
      gap_ticks_r    <= gap_ticks_nxt;
      bank_r         <= bank_nxt;
      if (cfg_valid) begin
        if (cfg_index == REG_FRAME_ID) begin
          frame_id_r <= cfg_data;
        end else if (cfg_index == REG_GAP_LIMIT) begin
          gap_limit_r <= cfg_data;
        end
      end
    end
  end

endmodule

FILE: hdl/ldf_cmdq.sv
// Two-entry queue of frame dump commands between front and back end.
module ldf_cmdq #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic [1:0]   level
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   level_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      level_r <= level_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head  = slot_r[rd_ptr_r];
  assign level = level_r;

endmodule

FILE: hdl/ldf_back.sv
// Back end: walks the store bank of a finished frame and presents its bytes.
module ldf_back
  import ldf_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [1:0]                     q_level,
  input  logic [$clog2(STORE_DEPTH+1):0] q_head,
  output logic                           q_pop,
  output logic                           busy,
  output logic                           rd_en,
  output logic [$clog2(STORE_DEPTH):0]   rd_addr,
  input  logic [7:0]                     rd_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output out_t                           out_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SHOW = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic          bank_r, bank_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] k_inc;
  logic          last;

  assign k_inc = k_r + 1'b1;
  assign last  = (k_inc == n_r);

  always_comb begin
    state_nxt = state_r;
    bank_nxt  = bank_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = {bank_r, AW'(k_inc)};
    unique case (state_r)
      S_IDLE: begin
        if (q_level != 2'd0) begin
          q_pop     = 1'b1;
          bank_nxt  = q_head[CW];
          n_nxt     = q_head[CW-1:0];
          k_nxt     = '0;
          rd_en     = 1'b1;
          rd_addr   = {q_head[CW], {AW{1'b0}}};
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_SHOW;
      end
      S_SHOW: begin
        if (out_ready) begin
          if (last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_inc;
            rd_en     = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bank_r <= bank_nxt;
    n_r    <= n_nxt;
    k_r    <= k_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = (state_r == S_SHOW);
  assign out_data.frame_byte = rd_data;
  assign out_data.byte_index = 5'(k_r);
  assign out_data.last       = last;

endmodule

FILE: hdl/length_framed_byte_deframer.sv
// A finished frame is queued as its final byte is taken, then dumped from the store.
// Throughput: one input transaction per cycle unless stalled; a frame dump reads each byte
//   from the store, then presents it, before reading the next.
// Input stalls only while two finished frames still own both store banks.
// Reset (rst_n low, synchronous): hunting, counters and queue cleared, frame_id 0,
//   gap_limit 10; store contents are not cleared.
module length_framed_byte_deframer
  import ldf_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  // Store holds two banks so one frame can be received while the previous dumps.
  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int CW    = $clog2(STORE_DEPTH + 1);
  localparam int RAW   = AW + 1;
  localparam int CMD_W = CW + 1;
  localparam int RAM_D = 2 << AW;

  logic             wr_en, rd_en;
  logic [RAW-1:0]   wr_addr, rd_addr;
  logic [7:0]       wr_data, rd_data;
  logic             push, pop;
  logic [CMD_W-1:0] push_data, q_head;
  logic [1:0]       q_level;
  logic             back_busy;
  front_stat_t      stat;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  assign stat.q_level   = q_level;
  assign stat.back_busy = back_busy;

  // Front: parse transactions, write bytes into the active bank, push dump commands.
  ldf_front #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_data (push_data)
  );

  // Hold bank select and byte count for each finished frame.
  ldf_cmdq #(
    .W(CMD_W)
  ) u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .level     (q_level)
  );

  ldf_ram #(
    .W     (8),
    .DEPTH (RAM_D)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Back: advance through the bank, one result transaction per stored byte.
  ldf_back #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_level   (q_level),
    .q_head    (q_head),
    .q_pop     (pop),
    .busy      (back_busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/ldf_checker.sv
// Port-level checker for the deframer, bound to the top level.
module ldf_checker
  import ldf_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data,
  input logic cfg_valid,
  input logic cfg_ready
);

  logic [4:0] exp_idx_r;

  // Track the expected position of the next result byte within its frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= 5'd0;
    end else if (out_valid && out_ready) begin
      exp_idx_r <= out_data.last ? 5'd0 : exp_idx_r + 5'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_idx_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.byte_index == exp_idx_r)
    else $error("byte_index out of sequence");

  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("not idle and ready after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("register write stalled");

endmodule

bind length_framed_byte_deframer ldf_checker u_ldf_checker (.*);

FILE: tb/tb_length_framed_byte_deframer.sv
// Self-checking testbench for the length-framed byte deframer: random and directed traffic.
module tb_length_framed_byte_deframer
  import ldf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH  = STORE_DEPTH_DEF;
  localparam int SETTLE = 10;  // cycles to let the pipeline empty before a register write

  // Register slots beyond the two real ones; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = '0;

  length_framed_byte_deframer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and scoreboard storage.
  in_t  rx_items_pending[$];  // ticks and bytes not yet offered to the block
  out_t frame_bytes_due[$];   // frame bytes the block still owes, oldest first
  int   items_queued   = 0;
  int   items_taken    = 0;
  int   mismatch_count = 0;
  int   send_idle_pct  = 0;
  int   recv_idle_pct  = 0;

  // Shadow copy of the deframer: registers and receive state.
  logic [7:0] cur_frame_id  = FRAME_ID_RST;
  logic [7:0] cur_gap_limit = GAP_LIMIT_RST;
  logic       rcv_active    = 1'b0;
  int         rcv_count     = 0;
  logic [7:0] rcv_length    = '0;
  logic [7:0] gap_ticks     = '0;
  logic [7:0] frame_buf[DEPTH];

  // Advance the shadow deframer by one transaction and queue any frame it completes.
  function automatic void deframe_step(in_t it);
    int   need;
    out_t ob;
    if (it.opcode == OP_TICK) begin
      // Count the idle tick; stick at saturation.
      if (gap_ticks != GAP_SAT) gap_ticks++;
      return;
    end
    // A late byte abandons the frame in progress, then is treated as a hunting byte.
    if (gap_ticks == GAP_SAT || gap_ticks > cur_gap_limit) begin
      rcv_active = 1'b0;
      rcv_count  = 0;
    end
    gap_ticks = '0;
    if (!rcv_active) begin
      // Hunt: only the frame ID opens a frame, anything else is dropped.
      if (rcv_count == 0 && it.rx_byte == cur_frame_id) begin
        frame_buf[0] = it.rx_byte;
        rcv_count    = 1;
        rcv_active   = 1'b1;
      end
      return;
    end
    if (rcv_count == 1) begin
      // Length byte: drop the frame at once if it cannot fit the store.
      rcv_length = it.rx_byte;
      if (rcv_length > DEPTH) begin
        rcv_active = 1'b0;
        rcv_count  = 0;
        return;
      end
      frame_buf[1] = it.rx_byte;
      rcv_count    = 2;
      return;
    end
    if (rcv_count >= DEPTH) begin
      rcv_active = 1'b0;
      rcv_count  = 0;
      return;
    end
    frame_buf[rcv_count] = it.rx_byte;
    rcv_count++;
    // Lengths below three still take three bytes.
    need = (rcv_length < 3) ? 3 : int'(rcv_length);
    if (rcv_count < need) return;
    for (int k = 0; k < rcv_count; k++) begin
      ob.frame_byte = frame_buf[k];
      ob.byte_index = k[4:0];
      ob.last       = (k == rcv_count - 1);
      frame_bytes_due.push_back(ob);
    end
    rcv_active = 1'b0;
    rcv_count  = 0;
  endfunction

  // Driver: retire the accepted transaction, then offer the next one or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_step(in_data);
        items_taken++;
      end
      // Hold valid and payload while the block stalls; otherwise pick anew.
      if (!in_valid || in_ready) begin
        if (rx_items_pending.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_data  <= rx_items_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted frame byte with the oldest one owed.
  always @(posedge clk) begin
    out_t due;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_bytes_due.size() == 0) begin
          $display("%0t: unexpected frame byte, expected none, got %p", $time, out_data);
          mismatch_count++;
        end else begin
          due = frame_bytes_due.pop_front();
          if (out_data.frame_byte !== due.frame_byte) begin
            $display("%0t: frame_byte expected %02h, got %02h",
                     $time, due.frame_byte, out_data.frame_byte);
            mismatch_count++;
          end
          if (out_data.byte_index !== due.byte_index) begin
            $display("%0t: byte_index expected %0d, got %0d",
                     $time, due.byte_index, out_data.byte_index);
            mismatch_count++;
          end
          if (out_data.last !== due.last) begin
            $display("%0t: last expected %0b, got %0b", $time, due.last, out_data.last);
            mismatch_count++;
          end
        end
      end
      // Stall the result side at random.
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  task automatic push_item(logic op, logic [7:0] b);
    in_t it;
    it.opcode  = op;
    it.rx_byte = b;
    rx_items_pending.push_back(it);
    items_queued++;
  endtask

  task automatic push_ticks(int n);
    // Ticks carry a random don't-care byte.
    repeat (n) push_item(OP_TICK, 8'($urandom));
  endtask

  // Queue one frame with the current ID; ticks fall between bytes, now and then
  // enough of them to time the frame out.
  task automatic push_frame(logic [7:0] len_byte, int gap_max, int abandon_pct);
    int n_bytes;
    int ticks;
    n_bytes = (len_byte < 3) ? 3 : int'(len_byte);
    push_item(OP_BYTE, cur_frame_id);
    for (int i = 1; i < n_bytes; i++) begin
      ticks = $urandom_range(gap_max, 0);
      if ($urandom_range(99, 0) < abandon_pct && cur_gap_limit < 8'd40)
        ticks = int'(cur_gap_limit) + 1 + $urandom_range(2, 0);
      push_ticks(ticks);
      push_item(OP_BYTE, (i == 1) ? len_byte : 8'($urandom));
      if (i == 1 && len_byte > DEPTH) break;
    end
  endtask

  // Mostly well-formed frames with random content; the rest oversize
  // headers, stray bytes and tick bursts.
  task automatic push_random_traffic(int n);
    int target;
    int kind;
    int pick;
    int gap_max;
    logic [7:0] len_byte;
    target = items_queued + n;
    while (items_queued < target) begin
      kind    = $urandom_range(99, 0);
      gap_max = (cur_gap_limit < 8'd6) ? int'(cur_gap_limit) : 6;
      if (kind < 72) begin
        pick = $urandom_range(99, 0);
        if (pick < 15)      len_byte = 8'($urandom_range(2, 0));
        else if (pick < 85) len_byte = 8'($urandom_range(8, 3));
        else if (pick < 95) len_byte = 8'($urandom_range(DEPTH - 1, 9));
        else                len_byte = 8'(DEPTH);
        push_frame(len_byte, gap_max, 4);
      end else if (kind < 80) begin
        push_item(OP_BYTE, cur_frame_id);
        push_item(OP_BYTE, ($urandom_range(1, 0) != 0) ? 8'(DEPTH + 1)
                                                        : 8'($urandom_range(255, DEPTH + 1)));
      end else if (kind < 92) begin
        push_item(OP_BYTE, 8'($urandom));
      end else begin
        push_ticks($urandom_range(3, 1));
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    // The write lands at this edge; mirror it, ignoring spare slots.
    case (idx)
      REG_FRAME_ID:  cur_frame_id  = val;
      REG_GAP_LIMIT: cur_gap_limit = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Wait until every transaction is taken and every owed byte has come out,
  // then let the pipeline go quiet.
  task automatic drain_and_settle();
    while (items_taken != items_queued || frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values of both registers: ID 0, gap limit 10.
    send_idle_pct = 20;
    recv_idle_pct = 82;
    push_ticks(1);
    push_item(OP_BYTE, 8'h55);                           // wrong opening byte
    push_item(OP_BYTE, 8'h00);                           // short length of one
    push_item(OP_BYTE, 8'h01);
    push_item(OP_BYTE, 8'hFF);
    push_item(OP_BYTE, 8'h00);                           // one past the store depth
    push_item(OP_BYTE, 8'(DEPTH + 1));
    push_item(OP_BYTE, 8'h00);                           // zero length
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'hAA);
    push_item(OP_BYTE, 8'h00);                           // frame cut by a gap timeout
    push_item(OP_BYTE, 8'h05);
    push_ticks(11);
    push_item(OP_BYTE, 8'h00);                           // restarts as a new frame
    push_item(OP_BYTE, 8'h03);
    push_item(OP_BYTE, 8'h80);
    push_random_traffic(30);
    drain_and_settle();

    // Top ID, zero gap limit; spare register slots must not disturb anything.
    send_idle_pct = 82;
    recv_idle_pct = 20;
    write_reg(REG_FRAME_ID, 8'hFF);
    write_reg(REG_GAP_LIMIT, 8'h00);
    write_reg(REG_SPARE_2, 8'h77);
    write_reg(REG_SPARE_3, 8'h01);
    push_random_traffic(30);
    drain_and_settle();

    // Gap limit of 255: only a saturated counter times a frame out, and the
    // counter holds at saturation instead of wrapping.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_FRAME_ID, 8'h5A);
    write_reg(REG_GAP_LIMIT, 8'hFF);
    push_item(OP_BYTE, 8'h5A);
    push_item(OP_BYTE, 8'h04);
    push_ticks(256);
    push_item(OP_BYTE, 8'h5A);                           // saturated: restart here
    push_item(OP_BYTE, 8'h03);
    push_item(OP_BYTE, 8'hEE);
    push_random_traffic(10);
    drain_and_settle();

    // Random ID and a small gap limit so the boundary tick count shows up often.
    write_reg(REG_FRAME_ID, 8'($urandom_range(254, 1)));
    write_reg(REG_GAP_LIMIT, 8'($urandom_range(6, 1)));
    push_random_traffic(30);
    drain_and_settle();

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Bound the run well past the slowest legal traffic pattern.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
